FILE: sv/izhikevich_neuron_step_top_defines.svh
// Assertion macros for the Izhikevich neuron step block.
// Used by izhikevich_neuron_step_top; expects i_clk and i_rst_n in scope.
`ifndef IZHIKEVICH_NEURON_STEP_TOP_DEFINES_SVH
`define IZHIKEVICH_NEURON_STEP_TOP_DEFINES_SVH

// same-cycle implication
`define IZN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IZN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/izn_pkg.sv
// Shared types, constants, saturation helpers and microcode ROM for the
// Izhikevich neuron step block. No dependencies.
package izn_pkg;

    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 31;

    localparam logic signed [31:0] K_QUAD  = 32'sd2621;
    localparam logic signed [31:0] K_LIN   = 32'sd327680;
    localparam logic signed [31:0] K_CONST = 32'sd9175040;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;

    localparam logic signed [31:0] RST_A   = 32'sd1311;
    localparam logic signed [31:0] RST_B   = 32'sd13107;
    localparam logic signed [31:0] RST_C   = -32'sd4259840;
    localparam logic signed [31:0] RST_D   = 32'sd524288;
    localparam logic signed [31:0] RST_THR = 32'sd1966080;
    localparam logic [30:0]        RST_DT  = 31'd65536;

    typedef enum logic [1:0] {
        CMD_SPIKE   = 2'd0,
        CMD_CURRENT = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A   = 3'd0,
        CFG_B   = 3'd1,
        CFG_C   = 3'd2,
        CFG_D   = 3'd3,
        CFG_THR = 3'd4,
        CFG_DT  = 3'd5
    } t_cfg;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_V, SRC_U, SRC_X, SRC_Y, SRC_SS, SRC_CS, SRC_Q,
        SRC_KQ, SRC_KL, SRC_K140, SRC_A, SRC_B, SRC_C, SRC_D, SRC_DT,
        SRC_W, SRC_AMT
    } t_src;

    typedef enum logic [2:0] {
        DST_NONE, DST_V, DST_U, DST_X, DST_Y, DST_SS, DST_CS
    } t_dst;

    typedef enum logic {
        AOP_ADD,
        AOP_SUB
    } t_aop;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_DONE,
        SEQ_JGT
    } t_seq;

    typedef struct packed {
        logic            mul_en;
        t_src            mul_a;
        t_src            mul_b;
        t_src            alu_a;
        t_src            alu_b;
        t_aop            alu_op;
        t_dst            dst;
        logic            set_fired;
        t_seq            seq;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   start;
    } t_ctl;

    localparam logic [PC_W-1:0] PC_SPIKE   = 5'd0;
    localparam logic [PC_W-1:0] PC_CURRENT = 5'd2;
    localparam logic [PC_W-1:0] PC_CLEAR   = 5'd4;
    localparam logic [PC_W-1:0] PC_STEP    = 5'd6;
    localparam logic [PC_W-1:0] PC_FIRE    = 5'd21;

    function automatic logic signed [31:0] f_sat_add(input logic [32:0] s);
        logic signed [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? Q_MIN : Q_MAX;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // floor(p / 2^16) saturated to 32 bits
    function automatic logic signed [31:0] f_sat_prod(input logic signed [63:0] p);
        logic signed [31:0] r;
        if ((&p[63:47]) || !(|p[63:47])) begin
            r = p[47:16];
        end else begin
            r = p[63] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

    function automatic t_uword f_w(input logic me, input t_src ma, input t_src mb,
                                   input t_src aa, input t_src ab, input t_aop op,
                                   input t_dst d, input logic fi, input t_seq sq,
                                   input logic [PC_W-1:0] tg);
        t_uword w;
        w.mul_en    = me;
        w.mul_a     = ma;
        w.mul_b     = mb;
        w.alu_a     = aa;
        w.alu_b     = ab;
        w.alu_op    = op;
        w.dst       = d;
        w.set_fired = fi;
        w.seq       = sq;
        w.target    = tg;
        return w;
    endfunction

    function automatic t_uword f_nop();
        return f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_NONE,
                   1'b0, SEQ_NEXT, PC_SPIKE);
    endfunction

    function automatic logic [PC_W-1:0] f_entry(input t_cmd c);
        logic [PC_W-1:0] pc;
        unique case (c)
            CMD_SPIKE:   pc = PC_SPIKE;
            CMD_CURRENT: pc = PC_CURRENT;
            CMD_STEP:    pc = PC_STEP;
            CMD_CLEAR:   pc = PC_CLEAR;
            default:     pc = PC_CLEAR;
        endcase
        return pc;
    endfunction

    // Q is the saturated product of the previous multiply.
    function automatic t_uword f_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            // spike event
            5'd0:  w = f_w(1'b1, SRC_W, SRC_AMT, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_NONE,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd1:  w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_SS, SRC_Q, AOP_ADD, DST_SS,
                           1'b0, SEQ_DONE, PC_SPIKE);
            // current event
            5'd2:  w = f_w(1'b1, SRC_W, SRC_AMT, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_NONE,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd3:  w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_CS, SRC_Q, AOP_ADD, DST_CS,
                           1'b0, SEQ_DONE, PC_SPIKE);
            // clear
            5'd4:  w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_SS,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd5:  w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_CS,
                           1'b0, SEQ_DONE, PC_SPIKE);
            // Euler step
            5'd6:  w = f_w(1'b1, SRC_KQ, SRC_V, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_NONE,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd7:  w = f_w(1'b1, SRC_KL, SRC_V, SRC_Q, SRC_ZERO, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd8:  w = f_w(1'b1, SRC_X, SRC_V, SRC_Q, SRC_ZERO, AOP_ADD, DST_Y,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd9:  w = f_w(1'b1, SRC_B, SRC_V, SRC_Q, SRC_Y, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd10: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_Q, SRC_U, AOP_SUB, DST_Y,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd11: w = f_w(1'b1, SRC_A, SRC_Y, SRC_X, SRC_K140, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd12: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_X, SRC_U, AOP_SUB, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd13: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_X, SRC_CS, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd14: w = f_w(1'b1, SRC_X, SRC_DT, SRC_Q, SRC_ZERO, AOP_ADD, DST_Y,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd15: w = f_w(1'b1, SRC_Y, SRC_DT, SRC_Q, SRC_V, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd16: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_Q, SRC_U, AOP_ADD, DST_Y,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd17: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_X, SRC_SS, AOP_ADD, DST_X,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd18: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, AOP_ADD, DST_NONE,
                           1'b0, SEQ_JGT, PC_FIRE);
            5'd19: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_X, SRC_ZERO, AOP_ADD, DST_V,
                           1'b0, SEQ_NEXT, PC_SPIKE);
            5'd20: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_Y, SRC_ZERO, AOP_ADD, DST_U,
                           1'b0, SEQ_DONE, PC_SPIKE);
            // spike fired
            5'd21: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_C, SRC_ZERO, AOP_ADD, DST_V,
                           1'b1, SEQ_NEXT, PC_SPIKE);
            5'd22: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_Y, SRC_D, AOP_ADD, DST_U,
                           1'b0, SEQ_DONE, PC_SPIKE);
            default: w = f_w(1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, AOP_ADD,
                             DST_NONE, 1'b0, SEQ_DONE, PC_SPIKE);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/izn_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jump.
// Depends on izn_pkg.
module izn_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  izn_pkg::t_cmd i_cmd,
    input  logic          i_gt,
    output izn_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);
    import izn_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic            r_busy;
    logic            n_busy;
    t_uword          w_uw;

    always_comb begin
        w_uw = r_busy ? f_rom(r_pc) : f_nop();
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_pc   = f_entry(i_cmd);
                n_busy = 1'b1;
            end
        end else begin
            unique case (w_uw.seq)
                SEQ_DONE: n_busy = 1'b0;
                SEQ_JGT:  n_pc   = i_gt ? w_uw.target : r_pc + 1'b1;
                default:  n_pc   = r_pc + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_SPIKE;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctl.uw    = w_uw;
    assign o_ctl.start = i_start;
    assign o_busy      = r_busy;
    assign o_done      = r_busy && (w_uw.seq == SEQ_DONE);

endmodule

FILE: sv/izn_dp.sv
// Datapath: configuration and neuron state registers, one shared 32x32
// multiplier with product register, saturating adder. Depends on izn_pkg.
module izn_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  izn_pkg::t_ctl                      i_ctl,
    input  logic                               i_cfg_we,
    input  logic [izn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [izn_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [izn_pkg::DATA_W-1:0]  i_weight,
    input  logic signed [izn_pkg::DATA_W-1:0]  i_amount,
    output logic                               o_gt,
    output logic signed [izn_pkg::DATA_W-1:0]  o_potential,
    output logic                               o_fired
);
    import izn_pkg::*;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] u;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] ss;
        logic signed [31:0] cs;
        logic signed [31:0] q;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] dt;
        logic signed [31:0] w;
        logic signed [31:0] amt;
    } t_bank;

    logic signed [31:0] r_a, r_b, r_c, r_d, r_thr;
    logic [DT_W-1:0]    r_dt;
    logic signed [31:0] r_v, r_u, r_ss, r_cs, r_x, r_y;
    logic signed [31:0] r_w, r_amt;
    logic signed [63:0] r_prod;
    logic               r_fired;

    t_bank              w_bank;
    logic signed [31:0] s_mul_a, s_mul_b, s_alu_a, s_alu_b;
    logic signed [63:0] n_prod;
    logic [32:0]        s_sum;
    logic signed [31:0] s_res;

    function automatic logic signed [31:0] f_pick(input t_src s, input t_bank bk);
        logic signed [31:0] r;
        case (s)
            SRC_V:    r = bk.v;
            SRC_U:    r = bk.u;
            SRC_X:    r = bk.x;
            SRC_Y:    r = bk.y;
            SRC_SS:   r = bk.ss;
            SRC_CS:   r = bk.cs;
            SRC_Q:    r = bk.q;
            SRC_KQ:   r = K_QUAD;
            SRC_KL:   r = K_LIN;
            SRC_K140: r = K_CONST;
            SRC_A:    r = bk.a;
            SRC_B:    r = bk.b;
            SRC_C:    r = bk.c;
            SRC_D:    r = bk.d;
            SRC_DT:   r = bk.dt;
            SRC_W:    r = bk.w;
            SRC_AMT:  r = bk.amt;
            default:  r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        w_bank.v   = r_v;
        w_bank.u   = r_u;
        w_bank.x   = r_x;
        w_bank.y   = r_y;
        w_bank.ss  = r_ss;
        w_bank.cs  = r_cs;
        w_bank.q   = f_sat_prod(r_prod);
        w_bank.a   = r_a;
        w_bank.b   = r_b;
        w_bank.c   = r_c;
        w_bank.d   = r_d;
        w_bank.dt  = {1'b0, r_dt};
        w_bank.w   = r_w;
        w_bank.amt = r_amt;
    end

    always_comb begin
        s_mul_a = f_pick(i_ctl.uw.mul_a, w_bank);
        s_mul_b = f_pick(i_ctl.uw.mul_b, w_bank);
        s_alu_a = f_pick(i_ctl.uw.alu_a, w_bank);
        s_alu_b = f_pick(i_ctl.uw.alu_b, w_bank);
        n_prod  = s_mul_a * s_mul_b;
        if (i_ctl.uw.alu_op == AOP_SUB) begin
            s_sum = {s_alu_a[31], s_alu_a} - {s_alu_b[31], s_alu_b};
        end else begin
            s_sum = {s_alu_a[31], s_alu_a} + {s_alu_b[31], s_alu_b};
        end
        s_res = f_sat_add(s_sum);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= RST_A;
            r_b   <= RST_B;
            r_c   <= RST_C;
            r_d   <= RST_D;
            r_thr <= RST_THR;
            r_dt  <= RST_DT;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_idx))
                CFG_A:   r_a   <= i_cfg_data;
                CFG_B:   r_b   <= i_cfg_data;
                CFG_C:   r_c   <= i_cfg_data;
                CFG_D:   r_d   <= i_cfg_data;
                CFG_THR: r_thr <= i_cfg_data;
                CFG_DT:  r_dt  <= i_cfg_data[DT_W-1:0];
                default: ;
            endcase
        end
    end

    // neuron state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= RST_C;
            r_u     <= '0;
            r_ss    <= '0;
            r_cs    <= '0;
            r_fired <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_fired <= 1'b0;
            end else if (i_ctl.uw.set_fired) begin
                r_fired <= 1'b1;
            end
            case (i_ctl.uw.dst)
                DST_V:   r_v  <= s_res;
                DST_U:   r_u  <= s_res;
                DST_SS:  r_ss <= s_res;
                DST_CS:  r_cs <= s_res;
                default: ;
            endcase
        end
    end

    // scratch and operand registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_w   <= i_weight;
            r_amt <= i_amount;
        end
        if (i_ctl.uw.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_ctl.uw.dst == DST_X) begin
            r_x <= s_res;
        end
        if (i_ctl.uw.dst == DST_Y) begin
            r_y <= s_res;
        end
    end

    assign o_gt        = r_x > r_thr;
    assign o_potential = r_v;
    assign o_fired     = r_fired;

endmodule

FILE: sv/izhikevich_neuron_step_top.sv
// Izhikevich neuron step: one item at a time through a microcoded datapath.
// An item is accepted only while the sequencer is idle and no result is pending,
// so the next item waits until the last result is in the output register. Each
// item runs its ROM program on the single shared multiplier. Synchronous active-low
// reset: potential = reset_potential default, config defaults, u, sums, flags 0.
// Top level: handshake, result register, assertions. Uses izn_pkg, izn_seq, izn_dp.
`include "izhikevich_neuron_step_top_defines.svh"

module izhikevich_neuron_step_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_cmd,
    input  logic signed [izn_pkg::DATA_W-1:0]  i_weight,
    input  logic signed [izn_pkg::DATA_W-1:0]  i_amount,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_fired,
    output logic signed [izn_pkg::DATA_W-1:0]  o_membrane,
    input  logic                               i_cfg_we,
    input  logic [izn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [izn_pkg::DATA_W-1:0]         i_cfg_data
);
    import izn_pkg::*;

    t_ctl               w_ctl;
    logic               w_busy;
    logic               w_done;
    logic               w_gt;
    logic               w_start;
    logic               w_load;
    logic signed [31:0] w_potential;
    logic               w_fired;

    logic               r_pend;
    logic               n_pend;
    logic               r_out_valid;
    logic               r_out_fired;
    logic signed [31:0] r_out_membrane;

    assign o_in_stall = w_busy || r_pend;
    assign w_start    = i_in_valid && !o_in_stall;
    assign w_load     = r_pend && (!r_out_valid || !i_out_stall);

    izn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (t_cmd'(i_cmd)),
        .i_gt    (w_gt),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy),
        .o_done  (w_done)
    );

    izn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_weight    (i_weight),
        .i_amount    (i_amount),
        .o_gt        (w_gt),
        .o_potential (w_potential),
        .o_fired     (w_fired)
    );

    always_comb begin
        n_pend = r_pend;
        if (w_done) begin
            n_pend = 1'b1;
        end else if (w_load) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_fired    <= w_fired;
            r_out_membrane <= w_potential;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fired     = r_out_fired;
    assign o_membrane  = r_out_membrane;

    `IZN_ASSERT_NEXT(a_busy_after_accept, w_start, w_busy, "item accepted but sequencer idle")
    `IZN_ASSERT_NOW(a_busy_pend_excl, w_busy, !r_pend, "sequencer running with result pending")
    `IZN_ASSERT_NOW(a_out_from_pend, $rose(o_out_valid), $past(r_pend), "result without item")

endmodule
